@@ hdl/assert_macros.svh @@
// Assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define TCT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, held off while reset is asserted.
`define TCT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ hdl/tct_pkg.sv @@
// ----------------------------------------------------------------------------
// Text console teletype package
// Screen geometry, field widths, character codes and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package tct_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int ADDR_W  = $clog2(CELLS);

    // Fixed payload widths
    localparam int CMD_W   = 1;
    localparam int CHAR_W  = 8;
    localparam int IDX_W   = 11;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int OFF_W   = 11;
    localparam int CELL_W  = 16;
    localparam int ATTR_W  = 8;

    localparam int COL_XW  = COL_W + 1;
    localparam int ROW_XW  = ROW_W + 1;

    localparam int TAB_STEP    = 8;
    localparam int COPY_LAST   = CELLS - COLUMNS - 1;
    localparam int BLANK_START = (ROWS - 1) * COLUMNS;

    localparam logic [CMD_W-1:0]  CMD_PUT  = 1'b0;
    localparam logic [CMD_W-1:0]  CMD_READ = 1'b1;

    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

    typedef struct packed {
        logic clear_step;
        logic load_in;
        logic exec_put;
        logic copy_start;
        logic read_req;
        logic rd_capture;
        logic copy_step;
        logic blank_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic is_read;
        logic overflow;
        logic copy_last;
        logic cnt_last;
    } t_dp_stat;

endpackage

@@ hdl/tct_channels.sv @@
// ----------------------------------------------------------------------------
// Text console channels
// Request, result and attribute-write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface tct_in_if import tct_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;

    modport source (output valid, cmd, char_code, cell_index, input ready);
    modport sink   (input valid, cmd, char_code, cell_index, output ready);
endinterface

interface tct_out_if import tct_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [OFF_W-1:0]  cursor_offset;
    logic              did_scroll;
    logic [CELL_W-1:0] cell_data;

    modport source (output valid, cursor_col, cursor_row, cursor_offset, did_scroll,
                    cell_data, input ready);
    modport sink   (input valid, cursor_col, cursor_row, cursor_offset, did_scroll,
                    cell_data, output ready);
endinterface

interface tct_cfg_if import tct_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ATTR_W-1:0] text_attribute;

    modport source (output valid, text_attribute, input ready);
    modport sink   (input valid, text_attribute, output ready);
endinterface

@@ hdl/text_console_teletype_top.sv @@
// ----------------------------------------------------------------------------
// Text console teletype top level
// Put-character and cell-read engine over an 80 x 25 text screen.
// ----------------------------------------------------------------------------
// After reset the block sweeps the screen memory to blank cells (0x0720), one
// cell a cycle, before it takes its first request; attribute writes are taken
// at any time. A put that does not scroll and a read both load their result
// once the result register is free, the read after the registered memory read.
// A put that scrolls moves 1920 cells through the memory one a cycle, reading
// one cell while writing the one read the cycle before, and blanks the 80
// bottom cells. The next request is taken while a result still waits.
module text_console_teletype_top import tct_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tct_in_if.sink     i_in,
    tct_out_if.source  o_out,
    tct_cfg_if.sink    i_cfg
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    assign i_cfg.ready = 1'b1;

    tct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    tct_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_req_cmd  (i_in.cmd),
        .i_req_char (i_in.char_code),
        .i_req_idx  (i_in.cell_index),
        .i_attr_we  (i_cfg.valid),
        .i_attr     (i_cfg.text_attribute),
        .o_col      (o_out.cursor_col),
        .o_row      (o_out.cursor_row),
        .o_off      (o_out.cursor_offset),
        .o_scroll   (o_out.did_scroll),
        .o_cell     (o_out.cell_data)
    );

endmodule

@@ hdl/tct_datapath.sv @@
// ----------------------------------------------------------------------------
// Text console datapath
// Screen memory, cursor, attribute, sweep counter and result register.
// ----------------------------------------------------------------------------
module tct_datapath import tct_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  logic [CMD_W-1:0]  i_req_cmd,
    input  logic [CHAR_W-1:0] i_req_char,
    input  logic [IDX_W-1:0]  i_req_idx,
    input  logic              i_attr_we,
    input  logic [ATTR_W-1:0] i_attr,
    output logic [COL_W-1:0]  o_col,
    output logic [ROW_W-1:0]  o_row,
    output logic [OFF_W-1:0]  o_off,
    output logic              o_scroll,
    output logic [CELL_W-1:0] o_cell
);

    logic [CELL_W-1:0] r_mem [CELLS];
    logic [CELL_W-1:0] r_rdata;

    logic [CMD_W-1:0]  r_cmd;
    logic [CHAR_W-1:0] r_char;
    logic [IDX_W-1:0]  r_idx;
    logic [ATTR_W-1:0] r_attr;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [ADDR_W-1:0] r_cnt;
    logic              r_scroll;
    logic [CELL_W-1:0] r_cell;
    logic              r_cp_pend;
    logic [ADDR_W-1:0] r_cp_addr;

    logic [COL_W-1:0]  r_o_col;
    logic [ROW_W-1:0]  r_o_row;
    logic [OFF_W-1:0]  r_o_off;
    logic              r_o_scroll;
    logic [CELL_W-1:0] r_o_cell;

    logic [COL_XW-1:0] w_col_x;
    logic [COL_XW-1:0] w_tab_col;
    logic [COL_XW-1:0] w_nxt_col;
    logic [COL_W-1:0]  w_ncol;
    logic              w_row_inc;
    logic              w_put_we;
    logic [COL_W-1:0]  w_put_col;
    logic [CHAR_W-1:0] w_put_char;
    logic [ROW_XW-1:0] w_nrow_x;
    logic              w_overflow;
    logic [ADDR_W-1:0] w_row_base;
    logic              w_in_range;

    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [CELL_W-1:0] w_wdata;
    logic [ADDR_W-1:0] w_raddr;

    // Cursor movement for a put request
    always_comb begin
        w_col_x    = {1'b0, r_col};
        w_tab_col  = (w_col_x + COL_XW'(TAB_STEP)) & ~COL_XW'(TAB_STEP - 1);
        w_nxt_col  = w_col_x + COL_XW'(1);
        w_ncol     = r_col;
        w_row_inc  = 1'b0;
        w_put_we   = 1'b0;
        w_put_col  = r_col;
        w_put_char = r_char;
        unique case (r_char)
            CH_NL: begin
                w_ncol    = '0;
                w_row_inc = 1'b1;
            end
            CH_CR: begin
                w_ncol = '0;
            end
            CH_BS: begin
                if (r_col != '0) begin
                    w_ncol     = r_col - COL_W'(1);
                    w_put_we   = 1'b1;
                    w_put_col  = r_col - COL_W'(1);
                    w_put_char = CH_BLANK;
                end
            end
            CH_TAB: begin
                if (w_tab_col >= COL_XW'(COLUMNS)) begin
                    w_ncol    = '0;
                    w_row_inc = 1'b1;
                end else begin
                    w_ncol = w_tab_col[COL_W-1:0];
                end
            end
            default: begin
                w_put_we = 1'b1;
                if (w_nxt_col >= COL_XW'(COLUMNS)) begin
                    w_ncol    = '0;
                    w_row_inc = 1'b1;
                end else begin
                    w_ncol = w_nxt_col[COL_W-1:0];
                end
            end
        endcase
        w_nrow_x   = {1'b0, r_row} + ROW_XW'(w_row_inc);
        w_overflow = (w_nrow_x >= ROW_XW'(ROWS));
    end

    assign w_row_base = ADDR_W'(r_row) * ADDR_W'(COLUMNS);
    assign w_in_range = (32'(r_idx) < CELLS);

    // Memory port selection
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cnt;
        w_wdata = {RESET_ATTR, CH_BLANK};
        priority if (r_cp_pend) begin
            w_we    = 1'b1;
            w_waddr = r_cp_addr;
            w_wdata = r_rdata;
        end else if (i_cmd.clear_step) begin
            w_we    = 1'b1;
        end else if (i_cmd.exec_put && w_put_we) begin
            w_we    = 1'b1;
            w_waddr = w_row_base + ADDR_W'(w_put_col);
            w_wdata = {r_attr, w_put_char};
        end else if (i_cmd.blank_step) begin
            w_we    = 1'b1;
            w_wdata = {r_attr, CH_BLANK};
        end
        w_raddr = i_cmd.copy_step ? (r_cnt + ADDR_W'(COLUMNS)) : ADDR_W'(r_idx);
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr    <= RESET_ATTR;
            r_col     <= '0;
            r_row     <= '0;
            r_cnt     <= '0;
            r_cp_pend <= 1'b0;
        end else begin
            if (i_attr_we) begin
                r_attr <= i_attr;
            end
            // a copied cell is written in the cycle after its read
            r_cp_pend <= i_cmd.copy_step;
            if (i_cmd.exec_put) begin
                r_col <= w_ncol;
                r_row <= w_overflow ? ROW_W'(ROWS - 1) : w_nrow_x[ROW_W-1:0];
            end
            priority if (i_cmd.copy_start) begin
                r_cnt <= '0;
            end else if (i_cmd.copy_step) begin
                r_cnt <= o_stat.copy_last ? ADDR_W'(BLANK_START) : r_cnt + ADDR_W'(1);
            end else if (i_cmd.clear_step || i_cmd.blank_step) begin
                r_cnt <= r_cnt + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd  <= i_req_cmd;
            r_char <= i_req_char;
            r_idx  <= i_req_idx;
        end
        r_cp_addr <= r_cnt;
        if (i_cmd.exec_put) begin
            r_scroll <= w_overflow;
            r_cell   <= '0;
        end
        if (i_cmd.read_req) begin
            r_scroll <= 1'b0;
        end
        if (i_cmd.rd_capture) begin
            r_cell <= w_in_range ? r_rdata : '0;
        end
        if (i_cmd.out_load) begin
            r_o_col    <= r_col;
            r_o_row    <= r_row;
            r_o_off    <= OFF_W'(w_row_base + ADDR_W'(r_col));
            r_o_scroll <= r_scroll;
            r_o_cell   <= r_cell;
        end
    end

    assign o_stat.is_read   = (r_cmd == CMD_READ);
    assign o_stat.overflow  = w_overflow;
    assign o_stat.copy_last = (r_cnt == ADDR_W'(COPY_LAST));
    assign o_stat.cnt_last  = (r_cnt == ADDR_W'(CELLS - 1));

    assign o_col    = r_o_col;
    assign o_row    = r_o_row;
    assign o_off    = r_o_off;
    assign o_scroll = r_o_scroll;
    assign o_cell   = r_o_cell;

endmodule

@@ hdl/tct_ctrl.sv @@
// ----------------------------------------------------------------------------
// Text console controller
// Sequences the clearing pass, request execution, scroll and result handoff.
// ----------------------------------------------------------------------------
module tct_ctrl import tct_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_COPY,
        S_DRAIN,
        S_BLANK,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_stat.cnt_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.is_read) begin
                    o_cmd.read_req = 1'b1;
                    n_state        = S_RDWAIT;
                end else begin
                    o_cmd.exec_put = 1'b1;
                    if (i_stat.overflow) begin
                        o_cmd.copy_start = 1'b1;
                        n_state          = S_COPY;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_RDWAIT: begin
                o_cmd.rd_capture = 1'b1;
                n_state          = S_DONE;
            end
            S_COPY: begin
                o_cmd.copy_step = 1'b1;
                if (i_stat.copy_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_BLANK;
            end
            S_BLANK: begin
                o_cmd.blank_step = 1'b1;
                if (i_stat.cnt_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ hdl/tct_checker.sv @@
// ----------------------------------------------------------------------------
// Text console port checker
// Result-channel checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tct_checker import tct_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [COL_W-1:0]  i_out_col,
    input logic [ROW_W-1:0]  i_out_row,
    input logic [OFF_W-1:0]  i_out_off,
    input logic              i_out_scroll,
    input logic [CELL_W-1:0] i_out_cell
);

    `TCT_ASSERT_NEXT(a_out_valid_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `TCT_ASSERT_NEXT(a_out_payload_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_off) && $stable(i_out_cell) && $stable(i_out_scroll))
    `TCT_ASSERT_IMPL(a_offset_match, i_clk, i_rst_n, i_out_valid, (32'(i_out_row) * COLUMNS + 32'(i_out_col)) == 32'(i_out_off))
    `TCT_ASSERT_IMPL(a_scroll_bottom, i_clk, i_rst_n, i_out_valid && i_out_scroll, (32'(i_out_row) == ROWS - 1) && (i_out_cell == '0))
    `TCT_ASSERT_IMPL(a_cursor_bounds, i_clk, i_rst_n, i_out_valid, (32'(i_out_col) < COLUMNS) && (32'(i_out_row) < ROWS))

endmodule

bind text_console_teletype_top tct_checker u_tct_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_col    (o_out.cursor_col),
    .i_out_row    (o_out.cursor_row),
    .i_out_off    (o_out.cursor_offset),
    .i_out_scroll (o_out.did_scroll),
    .i_out_cell   (o_out.cell_data)
);

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text console teletype testbench
// Sends put-character and cell-read requests to the console through its
// handshake channels and keeps a shadow of the screen, cursor and attribute.
// Each result is checked field by field against the oldest prediction. The
// run is split into phases with different idling on each side, and the text
// attribute is rewritten between phases.
// ----------------------------------------------------------------------------
module tb;
    import tct_pkg::*;

    typedef struct packed {
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic [OFF_W-1:0]  cursor_offset;
        logic              did_scroll;
        logic [CELL_W-1:0] cell_data;
    } t_cursor_report;

    // Shadow of the console: screen cells, cursor, attribute and the queue of
    // reports still owed by the block.
    class t_teletype_shadow;
        bit [CELL_W-1:0] screen [CELLS];
        int unsigned     col;
        int unsigned     row;
        bit [ATTR_W-1:0] attr;
        t_cursor_report  awaited[$];
        int unsigned     mismatches;

        function new();
            foreach (screen[i]) screen[i] = {RESET_ATTR, CH_BLANK};
            col        = 0;
            row        = 0;
            attr       = RESET_ATTR;
            mismatches = 0;
        endfunction

        function void scroll_screen();
            int i;
            for (i = 0; i + COLUMNS < CELLS; i++) screen[i] = screen[i + COLUMNS];
            for (i = BLANK_START; i < CELLS; i++) screen[i] = {attr, CH_BLANK};
            row = ROWS - 1;
        endfunction

        function void note_request(bit [CMD_W-1:0] cmd, bit [CHAR_W-1:0] ch,
                                   bit [IDX_W-1:0] idx);
            t_cursor_report rep;
            int unsigned    ofs;
            rep = '0;
            if (cmd == CMD_READ) begin
                if (idx < CELLS) rep.cell_data = screen[idx];
            end else begin
                case (ch)
                    CH_NL: begin
                        col = 0;
                        row++;
                    end
                    CH_CR: col = 0;
                    CH_BS: begin
                        if (col > 0) begin
                            col--;
                            screen[row * COLUMNS + col] = {attr, CH_BLANK};
                        end
                    end
                    CH_TAB: begin
                        col = (col + TAB_STEP) & ~(TAB_STEP - 1);
                        if (col >= COLUMNS) begin
                            col = 0;
                            row++;
                        end
                    end
                    default: begin
                        screen[row * COLUMNS + col] = {attr, ch};
                        col++;
                        if (col >= COLUMNS) begin
                            col = 0;
                            row++;
                        end
                    end
                endcase
                if (row >= ROWS) begin
                    scroll_screen();
                    rep.did_scroll = 1'b1;
                end
            end
            ofs               = row * COLUMNS + col;
            rep.cursor_col    = col[COL_W-1:0];
            rep.cursor_row    = row[ROW_W-1:0];
            rep.cursor_offset = ofs[OFF_W-1:0];
            awaited.push_back(rep);
        endfunction

        function void check_result(t_cursor_report got);
            t_cursor_report want;
            if (awaited.size() == 0) begin
                $error("result with no request outstanding");
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            if (got.cursor_col !== want.cursor_col) begin
                $error("cursor_col: expected %0d, actual %0d", want.cursor_col, got.cursor_col);
                mismatches++;
            end
            if (got.cursor_row !== want.cursor_row) begin
                $error("cursor_row: expected %0d, actual %0d", want.cursor_row, got.cursor_row);
                mismatches++;
            end
            if (got.cursor_offset !== want.cursor_offset) begin
                $error("cursor_offset: expected %0d, actual %0d",
                       want.cursor_offset, got.cursor_offset);
                mismatches++;
            end
            if (got.did_scroll !== want.did_scroll) begin
                $error("did_scroll: expected %0d, actual %0d", want.did_scroll, got.did_scroll);
                mismatches++;
            end
            if (got.cell_data !== want.cell_data) begin
                $error("cell_data: expected %h, actual %h", want.cell_data, got.cell_data);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;

    t_teletype_shadow sb;

    tct_in_if  in_ch ();
    tct_out_if out_ch ();
    tct_cfg_if cfg_ch ();

    text_console_teletype_top i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #40_000_000;
        $display("FAIL text_console_teletype_top");
        $finish;
    end

    always @(posedge clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Outputs are stable between the falling and the next rising edge.
    always @(negedge clk) begin
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            sb.check_result({out_ch.cursor_col, out_ch.cursor_row, out_ch.cursor_offset,
                             out_ch.did_scroll, out_ch.cell_data});
        end
    end

    task automatic send_request(input bit [CMD_W-1:0] cmd, input bit [CHAR_W-1:0] ch,
                                input bit [IDX_W-1:0] idx);
        bit taken;
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.cmd        <= cmd;
        in_ch.char_code  <= ch;
        in_ch.cell_index <= idx;
        do begin
            @(negedge clk);
            taken = (in_ch.ready === 1'b1);
            @(posedge clk);
        end while (!taken);
        sb.note_request(cmd, ch, idx);
    endtask

    task automatic put_char(input bit [CHAR_W-1:0] ch);
        send_request(CMD_PUT, ch, IDX_W'($urandom_range(0, 2047)));
    endtask

    task automatic read_cell(input bit [IDX_W-1:0] idx);
        send_request(CMD_READ, CHAR_W'($urandom_range(0, 255)), idx);
    endtask

    // Drop valid, wait for every owed report, then let the block settle.
    task automatic drain(input int settle);
        in_ch.valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_attribute(input bit [ATTR_W-1:0] value);
        bit taken;
        drain(8);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.text_attribute <= value;
        do begin
            @(negedge clk);
            taken = (cfg_ch.ready === 1'b1);
            @(posedge clk);
        end while (!taken);
        cfg_ch.valid <= 1'b0;
        sb.attr = value;
    endtask

    // Mostly plain text lines with control codes mixed in, some raw bytes,
    // and reads aimed near the cursor or anywhere in the index range.
    task automatic run_text(input int count);
        int issued;
        int k;
        int base;
        int back;
        int burst;
        issued = 0;
        while (issued < count) begin
            k = $urandom_range(99);
            if (k < 18) begin
                if ($urandom_range(1)) begin
                    base = sb.row * COLUMNS + sb.col;
                    back = $urandom_range(0, 160);
                    read_cell(IDX_W'((back > base) ? 0 : base - back));
                end else begin
                    read_cell(IDX_W'($urandom_range(0, 2047)));
                end
                issued++;
            end else if (k < 27) begin
                // Occasional run of newlines to push the screen into scrolling.
                burst = ($urandom_range(9) == 0) ? $urandom_range(4, 12) : 1;
                repeat (burst) put_char(CH_NL);
                issued += burst;
            end else begin
                if (k < 31)      put_char(CH_CR);
                else if (k < 36) put_char(CH_BS);
                else if (k < 42) put_char(CH_TAB);
                else if (k < 50) put_char(CHAR_W'($urandom_range(0, 255)));
                else             put_char(CHAR_W'($urandom_range(8'h20, 8'h7E)));
                issued++;
            end
        end
    endtask

    initial begin
        int i;
        sb = new();
        send_idle_pct = 22;
        recv_idle_pct = 64;
        rst_n                 <= 1'b0;
        in_ch.valid           <= 1'b0;
        in_ch.cmd             <= CMD_PUT;
        in_ch.char_code       <= '0;
        in_ch.cell_index      <= '0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.text_attribute <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests under the reset attribute.
        put_char(CH_BS);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(CH_BS);
        read_cell(IDX_W'(0));
        read_cell(IDX_W'(1));
        put_char(CH_CR);
        put_char(CH_NL);
        read_cell(IDX_W'(CELLS - 1));
        read_cell(11'h7FF);
        for (i = 0; i < 9; i++) put_char(CH_TAB);
        for (i = 0; i < 7; i++) put_char(CHAR_W'(8'h41 + i));
        put_char(CH_TAB);

        write_attribute(8'h00);
        run_text(125);

        send_idle_pct = 64;
        recv_idle_pct = 22;
        write_attribute(8'hFF);
        run_text(125);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_attribute(ATTR_W'($urandom_range(0, 255)));
        run_text(125);

        drain(20);
        if (sb.mismatches == 0) begin
            $display("PASS text_console_teletype_top");
        end else begin
            $display("FAIL text_console_teletype_top");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/tct_pkg.sv
hdl/tct_channels.sv
hdl/tct_datapath.sv
hdl/tct_ctrl.sv
hdl/text_console_teletype_top.sv
hdl/tct_checker.sv
dv/tb.sv
